// ===== rtl/core/stx_len_etx_frame_receiver_assert.svh =====
// Assertion helpers shared by the receiver modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef STX_LEN_ETX_FRAME_RECEIVER_ASSERT_SVH
`define STX_LEN_ETX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SLRX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slrx_pkg.sv =====
`default_nettype none

package slrx_pkg;

    localparam int DEFAULT_FRAME_DEPTH = 256;
    localparam logic [8:0] FRAME_EXTRA = 9'd2;

    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_VALUE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_VALUE       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_BYTES    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_POSITION  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH_POSITION = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS   = 3'd5;

    localparam logic [7:0] RST_START_VALUE     = 8'd2;
    localparam logic [7:0] RST_END_VALUE       = 8'd3;
    localparam logic [7:0] RST_HEADER_BYTES    = 8'd4;
    localparam logic [7:0] RST_START_POSITION  = 8'd0;
    localparam logic [7:0] RST_LENGTH_POSITION = 8'd1;
    localparam logic [7:0] RST_TIMEOUT_TICKS   = 8'd10;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_RX   = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_STORED    = 3'd1,
        ST_DONE      = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_BAD_START = 3'd4,
        ST_DROPPED   = 3'd5,
        ST_TIMEOUT   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] start_value;
        logic [7:0] end_value;
        logic [7:0] header_bytes;
        logic [7:0] start_position;
        logic [7:0] length_position;
        logic [7:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    // Write into one bank of the frame store.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] addr;
        logic [7:0] data;
    } wr_t;

    // Byte written in the same cycle the current item's read was issued.
    typedef struct packed {
        logic       valid;
        logic       bank;
        logic [7:0] data;
    } fwd_t;

    typedef struct packed {
        status_t    status;
        logic       done;
        logic [8:0] frame_length;
        logic [7:0] read_data;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/slrx_bank_ram.sv =====
`default_nettype none

module slrx_bank_ram #(
    parameter int DEPTH = slrx_pkg::DEFAULT_FRAME_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/slrx_rx_engine.sv =====
`default_nettype none

module slrx_rx_engine #(
    parameter int FRAME_DEPTH = slrx_pkg::DEFAULT_FRAME_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire slrx_pkg::cfg_t  cfg,
    input  wire logic          commit,
    input  wire slrx_pkg::item_t item,
    input  wire logic [7:0]    bank0_q,
    input  wire logic [7:0]    bank1_q,
    input  wire slrx_pkg::fwd_t  fwd,
    output      slrx_pkg::wr_t   wr,
    output      slrx_pkg::res_t  res
);

    import slrx_pkg::*;

    localparam logic [8:0] DEPTH9 = 9'(FRAME_DEPTH);

    logic       bank_reg, bank_next;
    logic [7:0] wp_reg, wp_next;
    logic [7:0] tc_reg, tc_next;
    logic [8:0] cl_reg, cl_next;

    logic       wr_en_c;
    logic       done_c;
    status_t    status_c;
    logic [7:0] rdata_c;
    logic [7:0] q0, q1, q_cur, q_other, len_c;
    logic [8:0] pos9, total_c;

    // A byte written by the previous item to the address just read wins over
    // the stale memory output.
    assign q0 = (fwd.valid && !fwd.bank) ? fwd.data : bank0_q;
    assign q1 = (fwd.valid &&  fwd.bank) ? fwd.data : bank1_q;
    assign q_cur   = bank_reg ? q1 : q0;
    assign q_other = bank_reg ? q0 : q1;

    assign pos9    = {1'b0, wp_reg};
    assign len_c   = ({1'b0, cfg.length_position} < DEPTH9) ? q_cur : 8'd0;
    assign total_c = {1'b0, len_c} + FRAME_EXTRA;

    always_comb
    begin
        bank_next = bank_reg;
        wp_next   = wp_reg;
        tc_next   = tc_reg;
        cl_next   = cl_reg;
        wr_en_c   = 1'b0;
        done_c    = 1'b0;
        status_c  = ST_NONE;
        rdata_c   = 8'd0;
        unique case (cmd_t'(item.cmd))
            CMD_TICK:
            begin
                if (tc_reg != 8'd0)
                begin
                    tc_next = tc_reg - 8'd1;
                end
                else
                begin
                    wp_next  = 8'd0;
                    status_c = ST_TIMEOUT;
                end
            end
            CMD_RX:
            begin
                tc_next = cfg.timeout_ticks;
                if (wp_reg < cfg.header_bytes)
                begin
                    if (pos9 >= DEPTH9)
                    begin
                        wp_next  = 8'd0;
                        status_c = ST_DROPPED;
                    end
                    else
                    begin
                        wr_en_c = 1'b1;
                        if (wp_reg == cfg.start_position && item.rx_byte != cfg.start_value)
                        begin
                            wp_next  = 8'd0;
                            status_c = ST_BAD_START;
                        end
                        else
                        begin
                            wp_next  = wp_reg + 8'd1;
                            status_c = ST_STORED;
                        end
                    end
                end
                else if (total_c > DEPTH9 || pos9 >= total_c)
                begin
                    wp_next  = 8'd0;
                    status_c = ST_DROPPED;
                end
                else
                begin
                    wr_en_c = 1'b1;
                    if (pos9 == total_c - 9'd1)
                    begin
                        wp_next = 8'd0;
                        if (item.rx_byte == cfg.end_value)
                        begin
                            cl_next   = pos9 + 9'd1;
                            bank_next = ~bank_reg;
                            done_c    = 1'b1;
                            status_c  = ST_DONE;
                        end
                        else
                        begin
                            status_c = ST_BAD_END;
                        end
                    end
                    else
                    begin
                        wp_next  = wp_reg + 8'd1;
                        status_c = ST_STORED;
                    end
                end
            end
            CMD_READ:
            begin
                if ({1'b0, item.read_index} < cl_reg && {1'b0, item.read_index} < DEPTH9)
                begin
                    rdata_c = q_other;
                end
            end
            default:
            begin
                status_c = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            wp_reg   <= 8'd0;
            tc_reg   <= 8'd0;
            cl_reg   <= 9'd0;
        end
        else if (commit)
        begin
            bank_reg <= bank_next;
            wp_reg   <= wp_next;
            tc_reg   <= tc_next;
            cl_reg   <= cl_next;
        end
    end

    assign wr.en   = wr_en_c && commit;
    assign wr.bank = bank_reg;
    assign wr.addr = wp_reg;
    assign wr.data = item.rx_byte;

    assign res.status       = status_c;
    assign res.done         = done_c;
    assign res.frame_length = cl_next;
    assign res.read_data    = rdata_c;

    `include "stx_len_etx_frame_receiver_assert.svh"

    `SLRX_ASSERT_IMPL(a_bank_swap_on_done, bank_reg != $past(bank_reg),
                      $past(commit && done_c), "bank swapped without a completed frame")
    `SLRX_ASSERT_NEXT(a_timeout_reload, commit && item.cmd == CMD_RX,
                      tc_reg == $past(cfg.timeout_ticks),
                      "timeout not reloaded by a received byte")
    `SLRX_ASSERT_NEXT(a_position_step, commit && status_c == ST_STORED,
                      wp_reg == 8'($past(wp_reg) + 8'd1),
                      "write position did not advance by one")

endmodule

`default_nettype wire

// ===== rtl/core/stx_len_etx_frame_receiver.sv =====
// Channel   Dir  Fields (lowest bit up)
// s_*       in   tuser: command[1:0]; tdata: rx_byte[7:0], read_index[15:8]
// m_*       out  tdata: status[2:0], frame_done[3], frame_length[12:4],
//                read_data[20:13], zero[23:21]
// cfg_*     in   cfg_addr selects the register, cfg_data is written on cfg_we
//
// One item per cycle while m_tready does not stall the output; an accepted item
// passes through p_item_reg and out_reg before its result goes valid.
// The frame store is two banks, each with one read and one write port, read at
// accept and written when the item commits; a byte written in the cycle that
// accepts the next item, to the address it reads, is forwarded to that item.
// Reset clears the control state only; the frame store needs no clearing pass.
// A stall on m_tready holds the whole pipeline and drops s_tready in the same cycle.
`default_nettype none

module stx_len_etx_frame_receiver #(
    parameter int FRAME_DEPTH = slrx_pkg::DEFAULT_FRAME_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [slrx_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [slrx_pkg::IN_DATA_W-1:0]  s_tdata,  // rx_byte, read_index
    input  wire logic [slrx_pkg::IN_USER_W-1:0]  s_tuser,  // command
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [slrx_pkg::OUT_DATA_W-1:0] m_tdata   // status, frame_done,
                                                           // frame_length, read_data
);

    import slrx_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);

    cfg_t       cfg_reg;
    item_t      p_item_reg;
    logic       p_valid_reg;
    fwd_t       fwd_reg;
    res_t       out_reg;
    logic       out_valid_reg;

    logic       advance;
    logic       accept;
    logic       commit;
    logic [7:0] rd_addr;
    wr_t        wr_req;
    res_t       res;
    logic [7:0] bank0_q, bank1_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_value     <= RST_START_VALUE;
            cfg_reg.end_value       <= RST_END_VALUE;
            cfg_reg.header_bytes    <= RST_HEADER_BYTES;
            cfg_reg.start_position  <= RST_START_POSITION;
            cfg_reg.length_position <= RST_LENGTH_POSITION;
            cfg_reg.timeout_ticks   <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_START_VALUE:     cfg_reg.start_value     <= cfg_data;
                CFG_END_VALUE:       cfg_reg.end_value       <= cfg_data;
                CFG_HEADER_BYTES:    cfg_reg.header_bytes    <= cfg_data;
                CFG_START_POSITION:  cfg_reg.start_position  <= cfg_data;
                CFG_LENGTH_POSITION: cfg_reg.length_position <= cfg_data;
                CFG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign commit   = p_valid_reg && advance;

    // A received byte needs the length byte; a read needs the requested byte.
    assign rd_addr = (cmd_t'(s_tuser) == CMD_RX) ? cfg_reg.length_position
                                                 : s_tdata[15:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            fwd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg   <= s_tvalid;
            fwd_reg.valid <= accept && wr_req.en && (wr_req.addr == rd_addr);
            fwd_reg.bank  <= wr_req.bank;
            fwd_reg.data  <= wr_req.data;
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_item_reg.cmd        <= s_tuser;
            p_item_reg.rx_byte    <= s_tdata[7:0];
            p_item_reg.read_index <= s_tdata[15:8];
            out_reg               <= res;
        end
    end

    slrx_bank_ram #(
        .DEPTH (FRAME_DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_req.en && !wr_req.bank),
        .waddr (wr_req.addr[AW-1:0]),
        .wdata (wr_req.data),
        .re    (accept),
        .raddr (rd_addr[AW-1:0]),
        .rdata (bank0_q)
    );

    slrx_bank_ram #(
        .DEPTH (FRAME_DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_req.en && wr_req.bank),
        .waddr (wr_req.addr[AW-1:0]),
        .wdata (wr_req.data),
        .re    (accept),
        .raddr (rd_addr[AW-1:0]),
        .rdata (bank1_q)
    );

    slrx_rx_engine #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .commit  (commit),
        .item    (p_item_reg),
        .bank0_q (bank0_q),
        .bank1_q (bank1_q),
        .fwd     (fwd_reg),
        .wr      (wr_req),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.read_data, out_reg.frame_length,
                       out_reg.done, out_reg.status};

    `include "stx_len_etx_frame_receiver_assert.svh"

    `SLRX_ASSERT_IMPL(a_write_on_commit, wr_req.en, p_valid_reg && advance,
                      "frame store written without a committing item")
    `SLRX_ASSERT_IMPL(a_done_status, m_tvalid && out_reg.done, out_reg.status == ST_DONE,
                      "frame_done without done status")
    `SLRX_ASSERT_NEXT(a_forward_capture, accept && wr_req.en && (wr_req.addr == rd_addr),
                      fwd_reg.valid, "overlapping write not forwarded")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
    import slrx_pkg::*;

    localparam int DEPTH = DEFAULT_FRAME_DEPTH;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
        logic       given;
        res_t       want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]            cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // rx_byte[7:0], read_index[15:8]
    logic [IN_USER_W-1:0]  s_tuser;   // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // status[2:0], frame_done[3], frame_length[12:4],
                                      // read_data[20:13], zero[23:21]

    // Receiver state as the testbench sees it.
    cfg_t       rx_cfg;
    logic [7:0] frame_mem [2][DEPTH];
    bit         mem_valid [2][DEPTH];
    logic       rx_bank;
    logic [7:0] rx_pos;
    logic [7:0] tick_count;
    logic [8:0] done_len;

    res_t pending_results[$];
    int   errors;
    int   items_sent;
    int   results_seen;
    int   frames_done;
    bit   quiet;
    bit   hold_off;

    // Reset settings apply throughout this table.
    dir_row_t directed_tab [27] = '{
        '{CMD_TICK,   8'h00, 8'h00, 1'b1, '{ST_TIMEOUT,   1'b0, 9'd0, 8'd0}},
        '{CMD_READ,   8'h00, 8'h00, 1'b1, '{ST_NONE,      1'b0, 9'd0, 8'd0}},
        '{CMD_RX,     8'h55, 8'h00, 1'b1, '{ST_BAD_START, 1'b0, 9'd0, 8'd0}},
        '{CMD_RX,     8'h02, 8'h10, 1'b0, '0},
        '{CMD_RX,     8'h04, 8'h20, 1'b0, '0},
        '{CMD_RX,     8'h00, 8'h40, 1'b0, '0},
        '{CMD_RX,     8'hFF, 8'h80, 1'b0, '0},
        '{CMD_RX,     8'h80, 8'h01, 1'b0, '0},
        '{CMD_RX,     8'h03, 8'h02, 1'b1, '{ST_DONE,      1'b1, 9'd6, 8'd0}},
        '{CMD_READ,   8'hFF, 8'h00, 1'b0, '0},
        '{CMD_READ,   8'h00, 8'hFF, 1'b1, '{ST_NONE,      1'b0, 9'd6, 8'd0}},
        // A zero length leaves the header running past the end of the frame.
        '{CMD_RX,     8'h02, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h00, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h11, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h22, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h33, 8'h00, 1'b1, '{ST_DROPPED,   1'b0, 9'd6, 8'd0}},
        // Length 255 makes a frame too long for the store.
        '{CMD_RX,     8'h02, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'hFF, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h00, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h00, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h44, 8'h00, 1'b1, '{ST_DROPPED,   1'b0, 9'd6, 8'd0}},
        '{CMD_RX,     8'h02, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'h03, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'hAA, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'hBB, 8'h00, 1'b0, '0},
        '{CMD_RX,     8'hCC, 8'h00, 1'b1, '{ST_BAD_END,   1'b0, 9'd6, 8'd0}},
        '{CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, '{ST_NONE,      1'b0, 9'd6, 8'd0}}
    };

    stx_len_etx_frame_receiver #(
        .FRAME_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic res_t receive_step(logic [1:0] cmd, logic [7:0] b, logic [7:0] ridx);
        res_t       r;
        logic [7:0] pos;
        logic [8:0] total;
        r = '0;
        r.status = ST_NONE;
        pos = rx_pos;
        case (cmd)
            CMD_TICK:
            begin
                if (tick_count != 8'd0)
                begin
                    tick_count = tick_count - 8'd1;
                end
                else
                begin
                    rx_pos = 8'd0;
                    r.status = ST_TIMEOUT;
                end
            end
            CMD_RX:
            begin
                tick_count = rx_cfg.timeout_ticks;
                if (pos < rx_cfg.header_bytes)
                begin
                    frame_mem[rx_bank][pos] = b;
                    mem_valid[rx_bank][pos] = 1'b1;
                    if (pos == rx_cfg.start_position && b != rx_cfg.start_value)
                    begin
                        rx_pos = 8'd0;
                        r.status = ST_BAD_START;
                    end
                    else
                    begin
                        rx_pos = pos + 8'd1;
                        r.status = ST_STORED;
                    end
                end
                else
                begin
                    total = {1'b0, frame_mem[rx_bank][rx_cfg.length_position]} + FRAME_EXTRA;
                    if (total > 9'(DEPTH) || {1'b0, pos} >= total)
                    begin
                        rx_pos = 8'd0;
                        r.status = ST_DROPPED;
                    end
                    else
                    begin
                        frame_mem[rx_bank][pos] = b;
                        mem_valid[rx_bank][pos] = 1'b1;
                        if ({1'b0, pos} == total - 9'd1)
                        begin
                            rx_pos = 8'd0;
                            if (b == rx_cfg.end_value)
                            begin
                                done_len = {1'b0, pos} + 9'd1;
                                rx_bank = rx_bank ^ 1'b1;
                                r.done = 1'b1;
                                r.status = ST_DONE;
                            end
                            else
                            begin
                                r.status = ST_BAD_END;
                            end
                        end
                        else
                        begin
                            rx_pos = pos + 8'd1;
                            r.status = ST_STORED;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if ({1'b0, ridx} < done_len)
                begin
                    r.read_data = frame_mem[rx_bank ^ 1'b1][ridx];
                end
            end
            default: ;
        endcase
        r.frame_length = done_len;
        return r;
    endfunction

    // A byte past the header looks up the length byte, which may never have been written.
    function automatic bit length_unknown();
        return rx_pos >= rx_cfg.header_bytes
            && !mem_valid[rx_bank][rx_cfg.length_position];
    endfunction

    task automatic report_mismatch(string what);
        $display("result %0d: %s", results_seen, what);
        errors++;
    endtask

    task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [7:0] ridx, input bit given = 1'b0,
                             input res_t want = '0);
        res_t predicted;
        if (cmd == CMD_RX && length_unknown())
        begin
            cmd = CMD_READ;
        end
        if (!quiet && !hold_off && $urandom_range(0, 99) < 4)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {ridx, b};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        predicted = receive_step(cmd, b, ridx);
        if (predicted.done)
        begin
            frames_done++;
        end
        pending_results.push_back(given ? want : predicted);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic write_config(cfg_t c);
        write_reg(CFG_START_VALUE, c.start_value);
        write_reg(CFG_END_VALUE, c.end_value);
        write_reg(CFG_HEADER_BYTES, c.header_bytes);
        write_reg(CFG_START_POSITION, c.start_position);
        write_reg(CFG_LENGTH_POSITION, c.length_position);
        write_reg(CFG_TIMEOUT_TICKS, c.timeout_ticks);
        cfg_we <= 1'b0;
        rx_cfg = c;
    endtask

    function automatic cfg_t random_setting();
        cfg_t c;
        c.start_value = 8'($urandom_range(0, 255));
        c.end_value = 8'($urandom_range(0, 255));
        c.header_bytes = 8'($urandom_range(2, 8));
        c.length_position = 8'($urandom_range(0, c.header_bytes - 1));
        c.start_position = 8'((c.length_position + $urandom_range(1, c.header_bytes - 1))
                              % c.header_bytes);
        c.timeout_ticks = 8'($urandom_range(1, 20));
        return c;
    endfunction

    // One frame shaped to pass the start, length and end checks where the setting allows, unless corrupted.
    task automatic send_frame(bit allow_corrupt);
        int unsigned hb;
        int unsigned sp;
        int unsigned lp;
        int unsigned n;
        int          bad_at;
        logic [7:0]  b;
        hb = rx_cfg.header_bytes;
        sp = rx_cfg.start_position;
        lp = rx_cfg.length_position;
        if (lp >= hb)
        begin
            n = hb + $urandom_range(1, 8);
        end
        else if (sp == lp)
        begin
            n = rx_cfg.start_value + 2;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            n = $urandom_range(hb + 1, DEPTH);
        end
        else
        begin
            n = hb + 1 + $urandom_range(0, 6);
        end
        if (n > DEPTH)
        begin
            n = DEPTH;
        end
        bad_at = (allow_corrupt && $urandom_range(0, 9) == 0) ? int'($urandom_range(0, n - 1)) : -1;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i == sp)
            begin
                b = rx_cfg.start_value;
            end
            else if (i == lp && lp < hb)
            begin
                b = 8'(n - 2);
            end
            if (i == n - 1)
            begin
                b = rx_cfg.end_value;
            end
            if (i == bad_at)
            begin
                b = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            send_item(CMD_RX, b, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(int unsigned budget);
        int unsigned first;
        int unsigned burst;
        logic [7:0]  ridx;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_frame(1'b1);
                6:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
                    end
                end
                7:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        ridx = (done_len != 9'd0 && $urandom_range(0, 1) == 1)
                             ? 8'($urandom_range(0, done_len - 1))
                             : 8'($urandom_range(0, 255));
                        send_item(CMD_READ, 8'($urandom_range(0, 255)), ridx);
                    end
                end
                default:
                begin
                    burst = (rx_cfg.timeout_ticks < 12) ? rx_cfg.timeout_ticks + 2 : 4;
                    repeat ($urandom_range(1, burst))
                    begin
                        send_item(CMD_TICK, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
                    end
                end
            endcase
        end
        // Tick until reception restarts so the next setting begins on a clean frame.
        while (rx_pos != 8'd0)
        begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(negedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item %h", m_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 9'(m_tdata[2:0]), 9'(want.status));
                check_field("frame_done", 9'(m_tdata[3]), 9'(want.done));
                check_field("frame_length", m_tdata[12:4], want.frame_length);
                check_field("read_data", 9'(m_tdata[20:13]), 9'(want.read_data));
                check_field("padding", 9'(m_tdata[23:21]), 9'd0);
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("run did not finish in time");
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        quiet = 1'b0;
        hold_off = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        frames_done = 0;
        rx_cfg = '{RST_START_VALUE, RST_END_VALUE, RST_HEADER_BYTES,
                   RST_START_POSITION, RST_LENGTH_POSITION, RST_TIMEOUT_TICKS};
        rx_bank = 1'b0;
        rx_pos = 8'd0;
        tick_count = 8'd0;
        done_len = 9'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tab[i])
        begin
            send_item(directed_tab[i].cmd, directed_tab[i].rx_byte, directed_tab[i].read_index,
                      directed_tab[i].given, directed_tab[i].want);
        end
        drain();

        write_config('{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'd4, 8'd0, 8'd1, 8'd10});
        run_phase(80);

        // One-byte header: start and length share position zero, so frames are two bytes.
        write_config('{8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0});
        run_phase(60);

        // Longest header; the only frame that passes fills the whole bank.
        write_config('{8'd254, 8'd0, 8'd255, 8'd254, 8'd254, 8'd255});
        send_frame(1'b0);
        drain();

        // Length byte sits past the header and is whatever the bank last held there.
        write_config('{8'd255, 8'd0, 8'd2, 8'd0, 8'd5, 8'd3});
        run_phase(60);

        write_config(random_setting());
        hold_off = 1'b1;
        run_phase(100);

        write_config(random_setting());
        quiet = 1'b1;
        run_phase(80);
        quiet = 1'b0;

        repeat (8) @(posedge clk);
        $display("%0d items sent and %0d results checked, %0d frames completed",
                 items_sent, results_seen, frames_done);
        $display("six register settings, including the extreme header and timeout values");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/slrx_pkg.sv
rtl/core/slrx_bank_ram.sv
rtl/core/slrx_rx_engine.sv
rtl/core/stx_len_etx_frame_receiver.sv
tb/tb_top.sv
